[rtl/lrd_pkg.sv]
// Shared types and constants for the log record deframer.
// No dependencies; imported by every module of the block.
package lrd_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_MAGIC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE_LEN = 2'd2;

    localparam logic [31:0] RST_RECORD_MAGIC  = 32'h544B_564C;
    localparam logic [31:0] RST_MAX_KEY_LEN   = 32'h0400_0000;
    localparam logic [31:0] RST_MAX_VALUE_LEN = 32'h1000_0000;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    localparam logic [4:0] HDR_BYTES = 5'd25;
    localparam logic [4:0] HDR_SEQ   = 5'd4;
    localparam logic [4:0] HDR_TOMB  = 5'd12;
    localparam logic [4:0] HDR_KLEN  = 5'd13;
    localparam logic [4:0] HDR_VLEN  = 5'd17;
    localparam logic [4:0] HDR_HASH  = 5'd21;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_ERROR   = 2'd2;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    localparam logic [2:0] K_KEY       = 3'd0;
    localparam logic [2:0] K_VALUE     = 3'd1;
    localparam logic [2:0] K_OK        = 3'd2;
    localparam logic [2:0] K_BAD_MAGIC = 3'd3;
    localparam logic [2:0] K_BAD_SIZE  = 3'd4;
    localparam logic [2:0] K_BAD_CSUM  = 3'd5;
    localparam logic [2:0] K_TORN      = 3'd6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [63:0] sequence_res;
        logic        tombstone;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

[rtl/log_record_deframer_core.sv]
// Log record deframer top level: input beat register, parser and result queue.
// Depends on lrd_pkg, lrd_parse and lrd_outq.
// Path: an input beat waits in the input beat register until the result queue has room;
// its results then enter the queue and are offered in order, a status after its byte.
// Throughput: one input beat per cycle while the output side keeps up.
// Reset: synchronous, active low; restores register defaults and empties all state.
module log_record_deframer_core #(
    parameter int unsigned QDEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [7:0]                    i_log_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_kind,
    output logic [7:0]                    o_payload_byte,
    output logic [63:0]                   o_sequence_res,
    output logic                          o_tombstone,
    output logic [31:0]                   o_key_length,
    output logic [31:0]                   o_value_length,
    output logic                          o_last
);
    import lrd_pkg::*;

    logic       r_in_valid;
    logic       r_in_func;
    logic [7:0] r_in_byte;
    logic       room, go, accept;
    t_push      push;
    t_result    res;

    assign go      = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_func <= i_func;
            r_in_byte <= i_log_byte;
        end
    end

    lrd_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_go          (go),
        .i_func        (r_in_func),
        .i_byte        (r_in_byte),
        .o_push        (push)
    );

    lrd_outq #(
        .DEPTH (QDEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_room  (room),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_kind         = res.kind;
    assign o_payload_byte = res.payload_byte;
    assign o_sequence_res = res.sequence_res;
    assign o_tombstone    = res.tombstone;
    assign o_key_length   = res.key_length;
    assign o_value_length = res.value_length;
    assign o_last         = res.last;

endmodule

[rtl/lrd_parse.sv]
// Record parser: configuration registers, header assembly, FNV-1a hash and result
// generation for one byte per cycle while i_go is high. Depends on lrd_pkg.
module lrd_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_wr_data,
    input  logic                          i_go,
    input  logic                          i_func,
    input  logic [7:0]                    i_byte,
    output lrd_pkg::t_push                o_push
);
    import lrd_pkg::*;

    logic [31:0] r_magic_cfg, r_max_key, r_max_value;
    logic [1:0]  r_phase, n_phase;
    logic [4:0]  r_hcount, n_hcount;
    logic [31:0] r_hmagic, n_hmagic;
    logic [63:0] r_seq, n_seq;
    logic        r_tomb, n_tomb;
    logic [31:0] r_klen, n_klen;
    logic [31:0] r_vlen, n_vlen;
    logic [31:0] r_exp, n_exp;
    logic [32:0] r_pcount, n_pcount;
    logic [31:0] r_hash, n_hash;

    logic [4:0]  off;
    logic [32:0] total;
    logic [31:0] hash_step;
    logic        hash_ok;
    t_push       push;
    t_result     snap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_cfg <= RST_RECORD_MAGIC;
            r_max_key   <= RST_MAX_KEY_LEN;
            r_max_value <= RST_MAX_VALUE_LEN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_RECORD_MAGIC:  r_magic_cfg <= i_cfg_wr_data;
                CFG_MAX_KEY_LEN:   r_max_key   <= i_cfg_wr_data;
                CFG_MAX_VALUE_LEN: r_max_value <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hcount <= '0;
            r_hmagic <= '0;
            r_seq    <= '0;
            r_tomb   <= 1'b0;
            r_klen   <= '0;
            r_vlen   <= '0;
            r_exp    <= '0;
            r_pcount <= '0;
            r_hash   <= FNV_OFFSET;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_hmagic <= n_hmagic;
            r_seq    <= n_seq;
            r_tomb   <= n_tomb;
            r_klen   <= n_klen;
            r_vlen   <= n_vlen;
            r_exp    <= n_exp;
            r_pcount <= n_pcount;
            r_hash   <= n_hash;
        end
    end

    always_comb begin
        off       = '0;
        total     = {1'b0, r_klen} + {1'b0, r_vlen};
        hash_step = (r_hash ^ {24'd0, i_byte}) * FNV_PRIME;
        hash_ok   = 1'b0;
        n_phase   = r_phase;
        n_hcount  = r_hcount;
        n_hmagic  = r_hmagic;
        n_seq     = r_seq;
        n_tomb    = r_tomb;
        n_klen    = r_klen;
        n_vlen    = r_vlen;
        n_exp     = r_exp;
        n_pcount  = r_pcount;
        n_hash    = r_hash;
        push      = '0;
        snap      = '0;

        // snapshot of held fields before any update, for a torn tail
        snap.sequence_res = r_seq;
        snap.tombstone    = r_tomb;
        snap.key_length   = r_klen;
        snap.value_length = r_vlen;

        if (i_func == FUNC_END) begin
            if (r_phase == PH_PAYLOAD || (r_phase == PH_HEADER && r_hcount != '0)) begin
                push.count     = 2'd1;
                push.res0      = snap;
                push.res0.kind = K_TORN;
                push.res0.last = 1'b1;
            end
            n_phase  = PH_HEADER;
            n_hcount = '0;
            n_hmagic = '0;
            n_seq    = '0;
            n_tomb   = 1'b0;
            n_klen   = '0;
            n_vlen   = '0;
            n_exp    = '0;
            n_pcount = '0;
            n_hash   = FNV_OFFSET;
        end else if (r_phase == PH_HEADER) begin
            if (r_hcount == '0) begin
                n_hmagic = '0;
                n_seq    = '0;
                n_tomb   = 1'b0;
                n_klen   = '0;
                n_vlen   = '0;
                n_exp    = '0;
            end
            if (r_hcount < HDR_SEQ) begin
                off      = r_hcount;
                n_hmagic = n_hmagic | ({24'd0, i_byte} << {off[1:0], 3'b000});
            end else if (r_hcount < HDR_TOMB) begin
                off   = r_hcount - HDR_SEQ;
                n_seq = n_seq | ({56'd0, i_byte} << {off[2:0], 3'b000});
            end else if (r_hcount == HDR_TOMB) begin
                n_tomb = (i_byte != 8'd0);
            end else if (r_hcount < HDR_VLEN) begin
                off    = r_hcount - HDR_KLEN;
                n_klen = n_klen | ({24'd0, i_byte} << {off[1:0], 3'b000});
            end else if (r_hcount < HDR_HASH) begin
                off    = r_hcount - HDR_VLEN;
                n_vlen = n_vlen | ({24'd0, i_byte} << {off[1:0], 3'b000});
            end else begin
                off   = r_hcount - HDR_HASH;
                n_exp = n_exp | ({24'd0, i_byte} << {off[1:0], 3'b000});
            end
            n_hcount = r_hcount + 5'd1;

            snap.sequence_res = n_seq;
            snap.tombstone    = n_tomb;
            snap.key_length   = n_klen;
            snap.value_length = n_vlen;

            if (n_hcount == HDR_BYTES) begin
                n_pcount       = '0;
                n_hash         = FNV_OFFSET;
                push.count     = 2'd1;
                push.res0      = snap;
                push.res0.last = 1'b1;
                if (n_hmagic != r_magic_cfg) begin
                    push.res0.kind = K_BAD_MAGIC;
                    n_phase        = PH_ERROR;
                end else if (n_klen > r_max_key || n_vlen > r_max_value) begin
                    push.res0.kind = K_BAD_SIZE;
                    n_phase        = PH_ERROR;
                end else if (n_klen == '0 && n_vlen == '0) begin
                    if (FNV_OFFSET == n_exp) begin
                        push.res0.kind = K_OK;
                        n_phase        = PH_HEADER;
                        n_hcount       = '0;
                    end else begin
                        push.res0.kind = K_BAD_CSUM;
                        n_phase        = PH_ERROR;
                    end
                end else begin
                    push.count = 2'd0;
                    n_phase    = PH_PAYLOAD;
                end
            end
        end else if (r_phase == PH_PAYLOAD) begin
            n_hash                 = hash_step;
            n_pcount               = r_pcount + 33'd1;
            push.count             = 2'd1;
            push.res0              = snap;
            push.res0.kind         = (r_pcount < {1'b0, r_klen}) ? K_KEY : K_VALUE;
            push.res0.payload_byte = i_byte;
            push.res0.last         = 1'b1;
            if (n_pcount >= total) begin
                hash_ok        = (hash_step == r_exp);
                push.count     = 2'd2;
                push.res0.last = 1'b0;
                push.res1      = snap;
                push.res1.last = 1'b1;
                if (hash_ok) begin
                    push.res1.kind = K_OK;
                    n_phase        = PH_HEADER;
                    n_hcount       = '0;
                end else begin
                    push.res1.kind = K_BAD_CSUM;
                    n_phase        = PH_ERROR;
                end
            end
        end
    end

    assign o_push = i_go ? push : '0;

endmodule

[rtl/lrd_outq.sv]
// Result queue: takes up to two results per cycle, gives one per beat.
// Depends on lrd_pkg.
module lrd_outq #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lrd_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output lrd_pkg::t_result o_res
);
    import lrd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp, n_wp, n_rp, wp1;
    logic [CW-1:0]   r_count, n_count;
    logic            pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign wp1     = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rp];
    assign o_room  = (r_count <= CW'(DEPTH - 2));

    always_comb begin
        n_rp = r_rp;
        if (pop_ok) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        unique case (i_push.count)
            2'd1:    n_wp = wp1;
            2'd2:    n_wp = (wp1 == PW'(DEPTH - 1)) ? '0 : wp1 + PW'(1);
            default: n_wp = r_wp;
        endcase
        n_count = r_count + CW'(i_push.count) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp1] <= i_push.res1;
        end
    end

endmodule

[rtl/lrd_checker.sv]
// Port-level checks for the log record deframer, bound to the top level.
// Depends on lrd_pkg and log_record_deframer_core.
module lrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_payload_byte,
    input logic [63:0] o_sequence_res,
    input logic        o_last
);
    import lrd_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_kind) && $stable(o_payload_byte)
                               && $stable(o_sequence_res) && $stable(o_last))
        else $error("stalled result beat changed");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind <= K_TORN)
        else $error("result kind out of range");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_KEY && o_kind != K_VALUE |-> o_last)
        else $error("status result not marked last");

    a_status_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_KEY && o_kind != K_VALUE |-> o_payload_byte == 8'd0)
        else $error("status result carries a payload byte");

endmodule

bind log_record_deframer_core lrd_checker u_lrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_payload_byte (o_payload_byte),
    .o_sequence_res (o_sequence_res),
    .o_last         (o_last)
);

[verif/lrd_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the log record deframer: tracks register writes, predicts the result
// beats of every accepted input beat and compares them in order with the output channel.
// Depends on lrd_pkg only; instantiated beside the block by tb.
module lrd_scoreboard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_wr_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_func,
    input  logic [7:0]                    i_log_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [2:0]                    i_kind,
    input  logic [7:0]                    i_payload_byte,
    input  logic [63:0]                   i_sequence_res,
    input  logic                          i_tombstone,
    input  logic [31:0]                   i_key_length,
    input  logic [31:0]                   i_value_length,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import lrd_pkg::*;

    logic [31:0] magic_reg;
    logic [31:0] key_limit;
    logic [31:0] value_limit;

    logic [1:0]  phase;
    logic [4:0]  hdr_count;
    logic [31:0] hdr_magic;
    logic [63:0] rec_seq;
    logic        rec_tomb;
    logic [31:0] rec_klen;
    logic [31:0] rec_vlen;
    logic [31:0] rec_hash;
    logic [32:0] payload_seen;
    logic [31:0] run_hash;

    t_result deframed_q[$];
    int      fail_count = 0;
    int      checked = 0;
    int      pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked;

    function automatic t_result make_result(input logic [2:0] kind, input logic [7:0] b);
        t_result r;
        r.kind         = kind;
        r.payload_byte = b;
        r.sequence_res = rec_seq;
        r.tombstone    = rec_tomb;
        r.key_length   = rec_klen;
        r.value_length = rec_vlen;
        r.last         = 1'b0;
        return r;
    endfunction

    task automatic clear_record();
        phase        = PH_HEADER;
        hdr_count    = '0;
        hdr_magic    = '0;
        rec_seq      = '0;
        rec_tomb     = 1'b0;
        rec_klen     = '0;
        rec_vlen     = '0;
        rec_hash     = '0;
        payload_seen = '0;
        run_hash     = FNV_OFFSET;
    endtask

    function automatic t_result close_record();
        t_result r;
        if (run_hash == rec_hash) begin
            r         = make_result(K_OK, 8'h00);
            phase     = PH_HEADER;
            hdr_count = '0;
        end else begin
            r     = make_result(K_BAD_CSUM, 8'h00);
            phase = PH_ERROR;
        end
        return r;
    endfunction

    task automatic deframe_beat(input logic func, input logic [7:0] b);
        t_result     batch[$];
        logic [32:0] total;
        if (func == FUNC_END) begin
            if (phase == PH_PAYLOAD || (phase == PH_HEADER && hdr_count != 0))
                batch.insert(batch.size(), make_result(K_TORN, 8'h00));
            clear_record();
        end else if (phase == PH_HEADER) begin
            if (hdr_count == 0) begin
                hdr_magic = '0;
                rec_seq   = '0;
                rec_tomb  = 1'b0;
                rec_klen  = '0;
                rec_vlen  = '0;
                rec_hash  = '0;
            end
            if (hdr_count < HDR_SEQ)
                hdr_magic[8*hdr_count +: 8] = b;
            else if (hdr_count < HDR_TOMB)
                rec_seq[8*(hdr_count-HDR_SEQ) +: 8] = b;
            else if (hdr_count == HDR_TOMB)
                rec_tomb = (b != 8'h00);
            else if (hdr_count < HDR_VLEN)
                rec_klen[8*(hdr_count-HDR_KLEN) +: 8] = b;
            else if (hdr_count < HDR_HASH)
                rec_vlen[8*(hdr_count-HDR_VLEN) +: 8] = b;
            else
                rec_hash[8*(hdr_count-HDR_HASH) +: 8] = b;
            hdr_count = hdr_count + 5'd1;
            if (hdr_count == HDR_BYTES) begin
                payload_seen = '0;
                run_hash     = FNV_OFFSET;
                if (hdr_magic != magic_reg) begin
                    batch.insert(batch.size(), make_result(K_BAD_MAGIC, 8'h00));
                    phase = PH_ERROR;
                end else if (rec_klen > key_limit || rec_vlen > value_limit) begin
                    batch.insert(batch.size(), make_result(K_BAD_SIZE, 8'h00));
                    phase = PH_ERROR;
                end else if (rec_klen == 0 && rec_vlen == 0) begin
                    batch.insert(batch.size(), close_record());
                end else begin
                    phase = PH_PAYLOAD;
                end
            end
        end else if (phase == PH_PAYLOAD) begin
            total    = {1'b0, rec_klen} + {1'b0, rec_vlen};
            run_hash = (run_hash ^ {24'h0, b}) * FNV_PRIME;
            batch.insert(batch.size(),
                         make_result((payload_seen < {1'b0, rec_klen}) ? K_KEY : K_VALUE, b));
            payload_seen = payload_seen + 33'd1;
            if (payload_seen >= total)
                batch.insert(batch.size(), close_record());
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            deframed_q.insert(deframed_q.size(), batch[i]);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (deframed_q.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual kind %0d byte %02h",
                     $time, i_kind, i_payload_byte);
            fail_count++;
        end else begin
            want = deframed_q.pop_front();
            checked++;
            compare_field("kind", want.kind, i_kind);
            compare_field("payload_byte", want.payload_byte, i_payload_byte);
            compare_field("sequence_res", want.sequence_res, i_sequence_res);
            compare_field("tombstone", want.tombstone, i_tombstone);
            compare_field("key_length", want.key_length, i_key_length);
            compare_field("value_length", want.value_length, i_value_length);
            compare_field("last", want.last, i_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            magic_reg   = RST_RECORD_MAGIC;
            key_limit   = RST_MAX_KEY_LEN;
            value_limit = RST_MAX_VALUE_LEN;
            clear_record();
            deframed_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_in_valid && !i_in_stall)
                deframe_beat(i_func, i_log_byte);
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_RECORD_MAGIC:  magic_reg   = i_cfg_wr_data;
                    CFG_MAX_KEY_LEN:   key_limit   = i_cfg_wr_data;
                    CFG_MAX_VALUE_LEN: value_limit = i_cfg_wr_data;
                    default: ;
                endcase
            end
        end
        pending_cnt = deframed_q.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Regression top for log_record_deframer_core: clock, reset, register settings,
// record stimulus with random idling on both channels, watchdog and verdict.
// Depends on lrd_pkg, log_record_deframer_core and lrd_scoreboard.
module tb;
    import lrd_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;
    localparam int TOTAL_BEATS    = 550;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_wr_data;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_func;
    logic [7:0]           i_log_byte;
    logic                 o_valid;
    logic                 i_stall;
    logic [2:0]           o_kind;
    logic [7:0]           o_payload_byte;
    logic [63:0]          o_sequence_res;
    logic                 o_tombstone;
    logic [31:0]          o_key_length;
    logic [31:0]          o_value_length;
    logic                 o_last;

    int fail_count;
    int pending;
    int checked;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int beats_sent    = 0;
    int records_sent  = 0;
    int reg_writes    = 0;

    logic [31:0] cur_magic   = RST_RECORD_MAGIC;
    logic [31:0] cur_key_max = RST_MAX_KEY_LEN;
    logic [31:0] cur_val_max = RST_MAX_VALUE_LEN;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    log_record_deframer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_log_byte     (i_log_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_sequence_res (o_sequence_res),
        .o_tombstone    (o_tombstone),
        .o_key_length   (o_key_length),
        .o_value_length (o_value_length),
        .o_last         (o_last)
    );

    lrd_scoreboard u_scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_func         (i_func),
        .i_log_byte     (i_log_byte),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_kind         (o_kind),
        .i_payload_byte (o_payload_byte),
        .i_sequence_res (o_sequence_res),
        .i_tombstone    (o_tombstone),
        .i_key_length   (o_key_length),
        .i_value_length (o_value_length),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    function automatic int idle_length(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    initial begin : rx_side
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = idle_length(rx_idle_pct);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("log_record_deframer_core regression: fail");
        $finish;
    end

    task automatic send_beat(input logic func, input logic [7:0] b);
        int gap;
        gap = idle_length(tx_idle_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= func;
        i_log_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_end();
        send_beat(FUNC_END, 8'($urandom_range(255)));
        beats_sent++;
    endtask

    task automatic send_noise(input int count);
        repeat (count) begin
            send_beat(FUNC_BYTE, 8'($urandom_range(255)));
            beats_sent++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_RECORD_MAGIC:  cur_magic   = data;
            CFG_MAX_KEY_LEN:   cur_key_max = data;
            CFG_MAX_VALUE_LEN: cur_val_max = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(input logic [31:0] magic, input logic [31:0] key_max,
                             input logic [31:0] val_max);
        write_reg(CFG_RECORD_MAGIC, magic);
        write_reg(CFG_MAX_KEY_LEN, key_max);
        write_reg(CFG_MAX_VALUE_LEN, val_max);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // cut < 0 sends the whole record, otherwise only its first cut bytes
    task automatic send_record(input logic [31:0] magic, input logic [31:0] klen,
                               input logic [31:0] vlen, input bit with_payload,
                               input bit bad_csum, input int cut, input logic [7:0] tomb);
        logic [7:0]  rec[$];
        logic [7:0]  pay[$];
        logic [63:0] seq;
        logic [31:0] hash;
        int          total;
        seq   = {$urandom, $urandom};
        hash  = FNV_OFFSET;
        total = with_payload ? int'(klen + vlen) : 0;
        for (int i = 0; i < total; i++) begin
            pay.insert(pay.size(), 8'($urandom_range(255)));
            hash = (hash ^ {24'h0, pay[i]}) * FNV_PRIME;
        end
        if (bad_csum)
            hash = hash ^ ($urandom | 32'h1);
        for (int i = 0; i < 4; i++) rec.insert(rec.size(), magic[8*i +: 8]);
        for (int i = 0; i < 8; i++) rec.insert(rec.size(), seq[8*i +: 8]);
        rec.insert(rec.size(), tomb);
        for (int i = 0; i < 4; i++) rec.insert(rec.size(), klen[8*i +: 8]);
        for (int i = 0; i < 4; i++) rec.insert(rec.size(), vlen[8*i +: 8]);
        for (int i = 0; i < 4; i++) rec.insert(rec.size(), hash[8*i +: 8]);
        foreach (pay[i]) rec.insert(rec.size(), pay[i]);
        for (int i = 0; i < rec.size() && (cut < 0 || i < cut); i++) begin
            send_beat(FUNC_BYTE, rec[i]);
            beats_sent++;
        end
        records_sent++;
    endtask

    task automatic random_record(input int max_k, input int max_v);
        int          pick;
        int          k;
        int          v;
        logic [7:0]  tomb;
        logic [31:0] kl;
        logic [31:0] vl;
        pick = $urandom_range(99);
        k    = $urandom_range(max_k);
        v    = $urandom_range(max_v);
        tomb = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00;
        if (pick < 60) begin
            send_record(cur_magic, k, v, 1'b1, 1'b0, -1, tomb);
            if (k > cur_key_max || v > cur_val_max)
                send_end();
        end else if (pick < 70) begin
            send_record(cur_magic, k, v, 1'b1, 1'b1, -1, tomb);
            send_noise($urandom_range(4));
            send_end();
        end else if (pick < 76) begin
            send_record(cur_magic ^ ($urandom | 32'h1), $urandom, $urandom, 1'b0, 1'b0, -1,
                        tomb);
            send_noise($urandom_range(6));
            send_end();
        end else if (pick < 82 && (cur_key_max != '1 || cur_val_max != '1)) begin
            if (cur_key_max != '1 && (cur_val_max == '1 || $urandom_range(1) == 1)) begin
                kl = cur_key_max + 32'd1 + $urandom_range(~cur_key_max - 32'd1);
                vl = $urandom;
            end else begin
                kl = $urandom_range(cur_key_max);
                vl = cur_val_max + 32'd1 + $urandom_range(~cur_val_max - 32'd1);
            end
            send_record(cur_magic, kl, vl, 1'b0, 1'b0, -1, tomb);
            send_noise($urandom_range(3));
            send_end();
        end else if (pick < 94) begin
            send_record(cur_magic, k, v, 1'b1, 1'b0, $urandom_range(24 + k + v, 1), tomb);
            send_end();
        end else begin
            send_end();
        end
    endtask

    task automatic random_until(input int target, input int max_k, input int max_v);
        while (beats_sent < target)
            random_record(max_k, max_v);
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_func        <= FUNC_BYTE;
        i_log_byte    <= 8'h00;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_RECORD_MAGIC;
        i_cfg_wr_data <= 32'h0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_end();
        send_record(cur_magic, 0, 0, 1'b1, 1'b0, -1, 8'h00);
        send_record(cur_magic, 2, 3, 1'b1, 1'b0, -1, 8'hFF);
        send_record(cur_magic, 0, 1, 1'b1, 1'b0, -1, 8'h01);
        send_record(cur_magic, 1, 0, 1'b1, 1'b0, -1, 8'h80);
        send_record(cur_magic, 0, 0, 1'b1, 1'b1, -1, 8'h00);
        send_noise(2);
        send_end();
        send_record(cur_magic, 2, 2, 1'b1, 1'b1, -1, 8'h00);
        send_end();
        send_record(~cur_magic, 0, 0, 1'b0, 1'b0, -1, 8'h00);
        send_end();
        send_record(cur_magic, RST_MAX_KEY_LEN + 32'd1, 0, 1'b0, 1'b0, -1, 8'h00);
        send_end();
        send_record(cur_magic, RST_MAX_KEY_LEN, RST_MAX_VALUE_LEN + 32'd1, 1'b0, 1'b0, -1,
                    8'h00);
        send_end();
        send_record(cur_magic, 0, 0, 1'b1, 1'b0, 1, 8'h00);
        send_end();
        send_record(cur_magic, 4, 4, 1'b1, 1'b0, 10, 8'h00);
        send_end();
        send_record(cur_magic, 3, 3, 1'b1, 1'b0, 28, 8'h00);
        send_end();
        drain();

        configure($urandom, 8, 12);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        random_until(beats_sent + 50, 10, 14);
        hold_requests++;
        tx_idle_pct = 0;
        repeat (2) send_record(cur_magic, 3, 6, 1'b1, 1'b0, -1, 8'h00);
        drain();

        configure(32'hFFFF_FFFF, 32'h0, 32'h0);
        tx_idle_pct = 15;
        rx_idle_pct = 40;
        send_record(cur_magic, 0, 0, 1'b1, 1'b0, -1, 8'h00);
        send_record(cur_magic, 1, 0, 1'b0, 1'b0, -1, 8'h00);
        send_end();
        send_record(cur_magic, 0, 1, 1'b0, 1'b0, -1, 8'h00);
        send_end();
        random_until(beats_sent + 20, 1, 1);
        drain();

        configure(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_until(beats_sent + 30, 6, 10);
        drain();

        configure($urandom, 6, 10);
        tx_idle_pct = 50;
        rx_idle_pct = 50;
        random_until(TOTAL_BEATS, 6, 10);
        drain();

        $display("Covered %0d input beats in %0d records over %0d register writes;",
                 beats_sent, records_sent, reg_writes);
        $display("%0d result beats checked, %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("log_record_deframer_core regression: pass");
        else
            $display("log_record_deframer_core regression: fail");
        $finish;
    end

endmodule
